// ===== src/pnet_pkg.sv =====
// ----------------------------------------------------------------------------
// pnet_pkg
// Types, constants and the velocity threshold table of the pitch note event
// tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package pnet_pkg;

  localparam int PITCHES       = 32;
  localparam int PIDX_W        = $clog2(PITCHES);
  localparam int AGE_MAX       = 255;
  localparam int GLOBAL_MEMORY = 3;
  localparam int GLOBAL_AGE_MAX = 4;
  localparam int REL_MAX       = 15;

  localparam logic [63:0] VEL_FLOOR = 64'd98;
  localparam logic [63:0] VEL_SPAN  = 64'd10387;
  localparam logic [63:0] LN2_Q24   = 64'd11629080;
  localparam logic [63:0] VEL_DEN   = 64'd63504;

  // configuration register indexes
  localparam logic [3:0] CFG_NEW_FLOOR  = 4'd0;
  localparam logic [3:0] CFG_RETRIG     = 4'd1;
  localparam logic [3:0] CFG_GLOBAL     = 4'd2;
  localparam logic [3:0] CFG_ATTACK     = 4'd3;
  localparam logic [3:0] CFG_RELEASE    = 4'd4;
  localparam logic [3:0] CFG_REFRACT    = 4'd5;
  localparam logic [3:0] CFG_MEMORY     = 4'd6;
  localparam logic [3:0] CFG_BASE       = 4'd7;

  localparam logic EV_OFF = 1'b0;
  localparam logic EV_ON  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic        activity;
    logic        onset;
    logic [15:0] attack_level;
    logic [15:0] host_offset;
    logic        last_element;
  } in_item_t;

  typedef struct packed {
    logic        event_kind;
    logic [6:0]  note_pitch;
    logic [6:0]  note_velocity;
    logic [15:0] event_offset;
    logic        last_event;
  } out_item_t;

  // one loaded frame element
  typedef struct packed {
    logic        act;
    logic        onset;
    logic [15:0] attack;
  } frame_ent_t;

  // tracking state of one pitch
  typedef struct packed {
    logic        active;
    logic        onset_high;
    logic [3:0]  attack_cnt;
    logic [3:0]  release_cnt;
    logic [3:0]  refract_cnt;
    logic [15:0] pend_attack;
    logic [7:0]  pend_attack_age;
    logic [7:0]  pend_onset_age;
  } pitch_ent_t;

  typedef logic [127:0][15:0] vel_tab_t;

  // thresholds for velocities 2..127, entries 0 and 1 are zero
  function automatic vel_tab_t vel_table();
    vel_tab_t    t;
    logic [63:0] d, n, num, q, r, m, k, frac, log2q, lnq, off;
    t = '0;
    for (int v = 2; v < 128; v++) begin
      d   = 64'(2 * v - 3);
      n   = VEL_DEN - d * d;
      num = VEL_DEN << 30;
      q   = '0;
      r   = '0;
      // long division by shift and subtract
      for (int i = 63; i >= 0; i--) begin
        r = {r[62:0], num[i]};
        if (r >= n) begin
          r    = r - n;
          q[i] = 1'b1;
        end
      end
      m = q;
      k = '0;
      for (int j = 0; j < 40; j++) begin
        if (m >= 64'h8000_0000) begin
          m = m >> 1;
          k = k + 64'd1;
        end
      end
      frac = '0;
      for (int i = 0; i < 24; i++) begin
        m    = (m * m) >> 30;
        frac = frac << 1;
        if (m >= 64'h8000_0000) begin
          m    = m >> 1;
          frac = frac | 64'd1;
        end
      end
      log2q = (k << 24) | frac;
      lnq   = (log2q * LN2_Q24) >> 24;
      off   = ((lnq * VEL_SPAN + 64'hFF_FFFF) >> 24) + VEL_FLOOR;
      t[v]  = (off > 64'hFFFF) ? 16'hFFFF : off[15:0];
    end
    return t;
  endfunction

  localparam vel_tab_t VEL_THR = vel_table();

endpackage
`default_nettype wire

// ===== src/pitch_note_event_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// pitch_note_event_tracker_unit
// Loads per-pitch frame elements into a frame memory and, on the last element
// or a release-all command, walks a pitch state memory and emits note events.
// ----------------------------------------------------------------------------
// An element that is not last is only stored; busy stays low. A last element
// or release-all walks all pitches: each pitch is read, then evaluated, then
// may pass a note-off state and a 7-step velocity search with a note-on state;
// a finish state ends the walk. Each event is held until the next one is found
// and leaves the cycle after that, the final one the cycle after the finish.
// Synchronous reset clears config to defaults, pitch valid bits and counters.
`default_nettype none
module pitch_note_event_tracker_unit (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  pnet_pkg::in_item_t   in_data,
  output logic                 out_strobe,
  output pnet_pkg::out_item_t  out_data,
  input  wire                  cfg_we,
  input  wire  [3:0]           cfg_index,
  input  wire  [15:0]          cfg_wdata
);
  import pnet_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RD   = 7'b0000010,
    ST_EV   = 7'b0000100,
    ST_OFF  = 7'b0001000,
    ST_VEL  = 7'b0010000,
    ST_ON   = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [15:0] new_floor_r, retrig_floor_r, global_floor_r;
  logic [3:0]  attack_frames_r, release_frames_r, refract_frames_r;
  logic [7:0]  memory_frames_r;
  logic [6:0]  base_pitch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      new_floor_r      <= 16'd131;
      retrig_floor_r   <= 16'd164;
      global_floor_r   <= 16'd983;
      attack_frames_r  <= 4'd2;
      release_frames_r <= 4'd4;
      refract_frames_r <= 4'd6;
      memory_frames_r  <= 8'd12;
      base_pitch_r     <= 7'd40;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NEW_FLOOR: new_floor_r      <= cfg_wdata;
        CFG_RETRIG:    retrig_floor_r   <= cfg_wdata;
        CFG_GLOBAL:    global_floor_r   <= cfg_wdata;
        CFG_ATTACK:    attack_frames_r  <= cfg_wdata[3:0];
        CFG_RELEASE:   release_frames_r <= cfg_wdata[3:0];
        CFG_REFRACT:   refract_frames_r <= cfg_wdata[3:0];
        CFG_MEMORY:    memory_frames_r  <= cfg_wdata[7:0];
        CFG_BASE:      base_pitch_r     <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // memories and per-pitch valid bits
  frame_ent_t fmem [PITCHES];
  pitch_ent_t smem [PITCHES];
  logic [PITCHES-1:0] vld_r;

  frame_ent_t fm_q;
  pitch_ent_t st_q;
  logic       vld_q;

  logic [PIDX_W-1:0] elem_cnt_r, p_r;
  logic [15:0] peak_r, gatt_r;
  logic [2:0]  gage_r;
  logic        rel_r;
  logic [15:0] offset_r;

  logic accept, load_we;
  assign accept  = start && (state_r == ST_IDLE);
  assign load_we = accept && !in_data.mode;
  assign busy    = (state_r != ST_IDLE);

  // evaluation results
  logic       do_on_r, off_n, on_n;
  logic [15:0] e_r, e_n;
  pitch_ent_t st_n;
  logic [6:0] vcur_r;
  logic [2:0] bit_r;

  always_ff @(posedge clk) begin
    if (load_we) begin
      fmem[elem_cnt_r] <= '{act: in_data.activity, onset: in_data.onset,
                            attack: in_data.attack_level};
    end
    if (state_r == ST_EV && !rel_r) begin
      smem[p_r] <= st_n;
    end
    if (state_r == ST_RD) begin
      fm_q  <= fmem[p_r];
      st_q  <= smem[p_r];
      vld_q <= vld_r[p_r];
    end
  end

  // per-pitch update
  always_comb begin
    pitch_ent_t s;
    logic       rising, afresh, ofresh, gfresh;
    logic [4:0] c;
    logic [15:0] half;
    s      = vld_q ? st_q : '0;
    off_n  = 1'b0;
    on_n   = 1'b0;
    half   = {1'b0, gatt_r[15:1]};
    gfresh = (gage_r <= 3'(GLOBAL_MEMORY)) && (gatt_r >= global_floor_r);
    if (fm_q.attack > s.pend_attack) begin
      s.pend_attack     = fm_q.attack;
      s.pend_attack_age = '0;
    end else begin
      if (s.pend_attack_age != 8'(AGE_MAX)) s.pend_attack_age = s.pend_attack_age + 8'd1;
      if (s.pend_attack_age > memory_frames_r) s.pend_attack = '0;
    end
    rising       = fm_q.onset && !s.onset_high;
    s.onset_high = fm_q.onset;
    if (rising) s.pend_onset_age = '0;
    else if (s.pend_onset_age != 8'(AGE_MAX)) s.pend_onset_age = s.pend_onset_age + 8'd1;
    if (s.refract_cnt != '0) s.refract_cnt = s.refract_cnt - 4'd1;
    afresh = s.pend_attack_age <= memory_frames_r;
    ofresh = s.pend_onset_age <= memory_frames_r;
    e_n    = (s.pend_attack > half) ? s.pend_attack : half;
    c      = {1'b0, s.attack_cnt} + 5'd1;
    if (!s.active) begin
      if (fm_q.act) s.attack_cnt = (c < {1'b0, attack_frames_r}) ? c[3:0] : attack_frames_r;
      else          s.attack_cnt = '0;
      if (s.attack_cnt >= attack_frames_r &&
          ((ofresh && gfresh) || (afresh && s.pend_attack >= new_floor_r))) begin
        on_n              = 1'b1;
        s.active          = 1'b1;
        s.attack_cnt      = '0;
        s.release_cnt     = '0;
        s.refract_cnt     = refract_frames_r;
        s.pend_attack     = '0;
        s.pend_attack_age = '0;
        s.pend_onset_age  = 8'(AGE_MAX);
      end
    end else if (rising && s.refract_cnt == '0 &&
                 ((afresh && s.pend_attack >= retrig_floor_r) || gfresh)) begin
      off_n             = 1'b1;
      on_n              = 1'b1;
      s.refract_cnt     = refract_frames_r;
      s.pend_attack     = '0;
      s.pend_attack_age = '0;
      s.pend_onset_age  = 8'(AGE_MAX);
      s.release_cnt     = '0;
    end else if (!fm_q.act) begin
      if (s.release_cnt != 4'(REL_MAX)) s.release_cnt = s.release_cnt + 4'd1;
      if (s.release_cnt >= release_frames_r) begin
        off_n            = 1'b1;
        s.active         = 1'b0;
        s.attack_cnt     = '0;
        s.release_cnt    = '0;
        s.refract_cnt    = '0;
        s.pend_onset_age = 8'(AGE_MAX);
      end
    end else begin
      s.release_cnt = '0;
    end
    if (rel_r) begin
      off_n = vld_q && st_q.active;
      on_n  = 1'b0;
    end
    st_n = s;
  end

  // frame peak and global attack on accepted elements
  logic [15:0] fpeak;
  logic [2:0]  gage_inc;
  assign fpeak    = (in_data.attack_level > peak_r) ? in_data.attack_level : peak_r;
  assign gage_inc = (gage_r < 3'(GLOBAL_AGE_MAX)) ? gage_r + 3'd1 : gage_r;

  // event sequencing
  logic       at_end;
  state_t     adv_state;
  logic       push_v, flush;
  out_item_t  push_ev, pend_r, fin_ev;
  logic       pend_v_r;
  logic [6:0] cand;

  assign at_end    = (p_r == PIDX_W'(PITCHES - 1));
  assign adv_state = at_end ? ST_FIN : ST_RD;
  assign cand      = vcur_r | (7'd1 << bit_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept && (in_data.mode || in_data.last_element)) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_EV;
      ST_EV:   state_nxt = off_n ? ST_OFF : (on_n ? ST_VEL : adv_state);
      ST_OFF:  state_nxt = do_on_r ? ST_VEL : adv_state;
      ST_VEL:  if (bit_r == 3'd0) state_nxt = ST_ON;
      ST_ON:   state_nxt = adv_state;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    push_v  = (state_r == ST_OFF) || (state_r == ST_ON);
    flush   = (state_r == ST_FIN);
    push_ev.event_kind    = (state_r == ST_ON) ? EV_ON : EV_OFF;
    push_ev.note_pitch    = 7'(base_pitch_r + 7'(p_r));
    push_ev.note_velocity = (state_r == ST_ON) ? vcur_r : 7'd0;
    push_ev.event_offset  = offset_r;
    push_ev.last_event    = 1'b0;
    fin_ev                = pend_r;
    fin_ev.last_event     = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      vld_r      <= '0;
      elem_cnt_r <= '0;
      peak_r     <= '0;
      gatt_r     <= '0;
      gage_r     <= 3'(GLOBAL_AGE_MAX);
      pend_v_r   <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_we) begin
        if (in_data.last_element) begin
          elem_cnt_r <= '0;
          peak_r     <= '0;
          if (fpeak >= gatt_r) begin
            gatt_r <= fpeak;
            gage_r <= '0;
          end else begin
            gage_r <= gage_inc;
            if (gage_inc > 3'(GLOBAL_MEMORY)) gatt_r <= '0;
          end
        end else begin
          peak_r <= fpeak;
          if (elem_cnt_r != PIDX_W'(PITCHES - 1)) elem_cnt_r <= elem_cnt_r + PIDX_W'(1);
        end
      end
      if (state_r == ST_EV && !rel_r) vld_r[p_r] <= 1'b1;
      if (flush && rel_r) vld_r <= '0;
      // one-event holdback so the final event can carry last_event
      if (push_v) begin
        out_strobe <= pend_v_r;
        pend_v_r   <= 1'b1;
      end else if (flush) begin
        out_strobe <= pend_v_r;
        pend_v_r   <= 1'b0;
      end else begin
        out_strobe <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rel_r    <= in_data.mode;
      offset_r <= in_data.host_offset;
      p_r      <= '0;
    end
    if ((state_r == ST_EV || state_r == ST_OFF || state_r == ST_ON) &&
        state_nxt == ST_RD) begin
      p_r <= p_r + PIDX_W'(1);
    end
    if (state_r == ST_EV) begin
      do_on_r  <= on_n;
      e_r      <= e_n;
      vcur_r   <= '0;
      bit_r    <= 3'd6;
    end
    if (state_r == ST_VEL) begin
      if (VEL_THR[cand] <= e_r) vcur_r <= cand;
      bit_r <= bit_r - 3'd1;
    end
    if (push_v) begin
      out_data <= pend_r;
      pend_r   <= push_ev;
    end else if (flush) begin
      out_data <= fin_ev;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("event beat outside a walk");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.event_kind == EV_ON) |-> (out_data.note_velocity != 7'd0))
    else $error("note on with zero velocity");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.event_kind == EV_OFF) |-> (out_data.note_velocity == 7'd0))
    else $error("note off with nonzero velocity");

  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.mode || in_data.last_element)) |=> busy)
    else $error("walk did not start");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> !pend_v_r)
    else $error("held event left after walk");

endmodule
`default_nettype wire

// ===== tb/tb_pitch_note_event_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// tb_pitch_note_event_tracker_unit
// Drives frames of pitch elements and release-all commands into the note
// event tracker under several register settings, predicts every note event
// with an independent tracker model and checks each event field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_pitch_note_event_tracker_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import pnet_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_data = '0;
  logic        out_strobe;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  pitch_note_event_tracker_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // tracker registers
  logic [15:0] new_floor, retrig_floor, glob_floor;
  logic [3:0]  attack_need, release_need, refract_len;
  logic [7:0]  memory_len;
  logic [6:0]  base_note;

  // tracker state
  logic        fr_act [PITCHES];
  logic        fr_onset [PITCHES];
  logic [15:0] fr_attack [PITCHES];
  int          elem_idx;
  logic [15:0] frame_peak, glob_attack;
  int          glob_age;
  logic        active [PITCHES];
  logic        onset_high [PITCHES];
  int          attack_cnt [PITCHES];
  int          release_cnt [PITCHES];
  int          refract_cnt [PITCHES];
  logic [15:0] pend_attack [PITCHES];
  int          pend_attack_age [PITCHES];
  int          pend_onset_age [PITCHES];

  logic [15:0] vel_thr [128];

  out_item_t   events_due [$];
  int          errors = 0;
  int          cycles = 0;
  int          items_sent = 0;
  int          events_seen = 0;
  int          note_ons = 0;
  int          release_alls = 0;
  bit          quiet = 1'b0;

  function automatic void build_thresholds();
    longint unsigned d, n, m, k, frac, lq, off;
    for (int v = 2; v < 128; v++) begin
      d = 2 * v - 3;
      n = 63504 - d * d;
      m = (64'd63504 << 30) / n;
      k = 0;
      frac = 0;
      while (m >= 64'h8000_0000) begin
        m = m >> 1;
        k++;
      end
      for (int i = 0; i < 24; i++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= 64'h8000_0000) begin
          m = m >> 1;
          frac = frac | 1;
        end
      end
      lq = (((k << 24) | frac) * 64'd11629080) >> 24;
      off = ((lq * 64'd10387 + 64'hFF_FFFF) >> 24) + 98;
      vel_thr[v] = off > 64'hFFFF ? 16'hFFFF : off[15:0];
    end
  endfunction

  function automatic logic [6:0] velocity_for(int p);
    logic [15:0] e, half;
    logic [6:0]  vel;
    half = glob_attack >> 1;
    e = pend_attack[p] > half ? pend_attack[p] : half;
    vel = 7'd1;
    for (int v = 2; v < 128; v++)
      if (e >= vel_thr[v]) vel = 7'(v);
    return vel;
  endfunction

  function automatic void clear_pitch_state();
    for (int p = 0; p < PITCHES; p++) begin
      active[p] = 1'b0;
      onset_high[p] = 1'b0;
      attack_cnt[p] = 0;
      release_cnt[p] = 0;
      refract_cnt[p] = 0;
      pend_attack[p] = '0;
      pend_attack_age[p] = 0;
      pend_onset_age[p] = 0;
    end
  endfunction

  function automatic void push_event(ref out_item_t evs[$], input logic kind, input int p,
                                     input logic [6:0] vel, input logic [15:0] ofs);
    out_item_t e;
    e.event_kind = kind;
    e.note_pitch = base_note + 7'(p);
    e.note_velocity = vel;
    e.event_offset = ofs;
    e.last_event = 1'b0;
    evs.push_back(e);
  endfunction

  function automatic void walk_pitches(ref out_item_t evs[$], input logic [15:0] ofs);
    bit gfresh, act, on, rising, afresh, ofresh;
    if (frame_peak >= glob_attack) begin
      glob_attack = frame_peak;
      glob_age = 0;
    end else begin
      if (glob_age < 4) glob_age++;
      if (glob_age > 3) glob_attack = '0;
    end
    gfresh = glob_age <= 3 && glob_attack >= glob_floor;
    for (int p = 0; p < PITCHES; p++) begin
      act = fr_act[p];
      on = fr_onset[p];
      if (fr_attack[p] > pend_attack[p]) begin
        pend_attack[p] = fr_attack[p];
        pend_attack_age[p] = 0;
      end else begin
        if (pend_attack_age[p] < 255) pend_attack_age[p]++;
        if (pend_attack_age[p] > memory_len) pend_attack[p] = '0;
      end
      rising = on && !onset_high[p];
      onset_high[p] = on;
      if (rising) pend_onset_age[p] = 0;
      else if (pend_onset_age[p] < 255) pend_onset_age[p]++;
      if (refract_cnt[p] > 0) refract_cnt[p]--;
      afresh = pend_attack_age[p] <= memory_len;
      if (!active[p]) begin
        ofresh = pend_onset_age[p] <= memory_len;
        if (act) attack_cnt[p] = attack_cnt[p] + 1 < attack_need ? attack_cnt[p] + 1
                                                                 : attack_need;
        else attack_cnt[p] = 0;
        if (attack_cnt[p] >= attack_need &&
            ((ofresh && gfresh) || (afresh && pend_attack[p] >= new_floor))) begin
          push_event(evs, EV_ON, p, velocity_for(p), ofs);
          active[p] = 1'b1;
          attack_cnt[p] = 0;
          release_cnt[p] = 0;
          refract_cnt[p] = refract_len;
          pend_attack[p] = '0;
          pend_attack_age[p] = 0;
          pend_onset_age[p] = 255;
        end
      end else if (rising && refract_cnt[p] == 0 &&
                   ((afresh && pend_attack[p] >= retrig_floor) || gfresh)) begin
        // retrigger: off then on
        push_event(evs, EV_OFF, p, 7'd0, ofs);
        push_event(evs, EV_ON, p, velocity_for(p), ofs);
        refract_cnt[p] = refract_len;
        pend_attack[p] = '0;
        pend_attack_age[p] = 0;
        pend_onset_age[p] = 255;
        release_cnt[p] = 0;
      end else if (!act) begin
        if (release_cnt[p] < 15) release_cnt[p]++;
        if (release_cnt[p] >= release_need) begin
          push_event(evs, EV_OFF, p, 7'd0, ofs);
          active[p] = 1'b0;
          attack_cnt[p] = 0;
          release_cnt[p] = 0;
          refract_cnt[p] = 0;
          pend_onset_age[p] = 255;
        end
      end else begin
        release_cnt[p] = 0;
      end
    end
  endfunction

  function automatic void track_beat(in_item_t x);
    out_item_t evs[$];
    int idx;
    if (x.mode) begin
      release_alls++;
      for (int p = 0; p < PITCHES; p++)
        if (active[p]) push_event(evs, EV_OFF, p, 7'd0, x.host_offset);
      clear_pitch_state();
    end else begin
      idx = elem_idx;
      fr_act[idx] = x.activity;
      fr_onset[idx] = x.onset;
      fr_attack[idx] = x.attack_level;
      if (x.attack_level > frame_peak) frame_peak = x.attack_level;
      if (x.last_element) begin
        walk_pitches(evs, x.host_offset);
        elem_idx = 0;
        frame_peak = '0;
      end else if (elem_idx < PITCHES - 1) begin
        elem_idx++;
      end
    end
    if (evs.size() > 0) evs[evs.size() - 1].last_event = 1'b1;
    foreach (evs[i]) events_due.push_back(evs[i]);
  endfunction

  function automatic void reset_tracker();
    new_floor = 16'd131;
    retrig_floor = 16'd164;
    glob_floor = 16'd983;
    attack_need = 4'd2;
    release_need = 4'd4;
    refract_len = 4'd6;
    memory_len = 8'd12;
    base_note = 7'd40;
    elem_idx = 0;
    frame_peak = '0;
    glob_attack = '0;
    glob_age = 4;
    clear_pitch_state();
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_pitch_note_event_tracker_unit: FAIL");
      $finish;
    end
  end

  // event checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe) begin
      events_seen++;
      if (events_due.size() == 0) begin
        report("unexpected event pitch", 16'(out_data.note_pitch), 16'h0);
      end else begin
        want = events_due.pop_front();
        if (out_data.event_kind == EV_ON) note_ons++;
        if (out_data.event_kind !== want.event_kind)
          report("event_kind", 16'(out_data.event_kind), 16'(want.event_kind));
        if (out_data.note_pitch !== want.note_pitch)
          report("note_pitch", 16'(out_data.note_pitch), 16'(want.note_pitch));
        if (out_data.note_velocity !== want.note_velocity)
          report("note_velocity", 16'(out_data.note_velocity), 16'(want.note_velocity));
        if (out_data.event_offset !== want.event_offset)
          report("event_offset", out_data.event_offset, want.event_offset);
        if (out_data.last_event !== want.last_event)
          report("last_event", 16'(out_data.last_event), 16'(want.last_event));
      end
    end
  end

  task automatic idle(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_beat(in_item_t x);
    if (!quiet && $urandom_range(0, 3) == 0) idle($urandom_range(1, 12));
    in_data <= x;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    track_beat(x);
    items_sent++;
  endtask

  task automatic send_element(bit act, bit on, logic [15:0] energy, bit last);
    in_item_t x;
    x.mode = 1'b0;
    x.activity = act;
    x.onset = on;
    x.attack_level = energy;
    x.host_offset = 16'($urandom);
    x.last_element = last;
    send_beat(x);
  endtask

  task automatic send_release_all();
    in_item_t x;
    x = in_item_t'($urandom);
    x.mode = 1'b1;
    x.host_offset = 16'($urandom);
    send_beat(x);
  endtask

  task automatic wait_idle();
    idle(1);
    while (events_due.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_NEW_FLOOR: new_floor = val;
      CFG_RETRIG:    retrig_floor = val;
      CFG_GLOBAL:    glob_floor = val;
      CFG_ATTACK:    attack_need = val[3:0];
      CFG_RELEASE:   release_need = val[3:0];
      CFG_REFRACT:   refract_len = val[3:0];
      CFG_MEMORY:    memory_len = val[7:0];
      CFG_BASE:      base_note = val[6:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] nf, logic [15:0] rf, logic [15:0] gf,
                           logic [15:0] af, logic [15:0] rl, logic [15:0] rr,
                           logic [15:0] mem, logic [15:0] bp);
    wait_idle();
    write_reg(CFG_NEW_FLOOR, nf);
    write_reg(CFG_RETRIG, rf);
    write_reg(CFG_GLOBAL, gf);
    write_reg(CFG_ATTACK, af);
    write_reg(CFG_RELEASE, rl);
    write_reg(CFG_REFRACT, rr);
    write_reg(CFG_MEMORY, mem);
    write_reg(CFG_BASE, bp);
    // indexes past the last register must be ignored
    write_reg(4'($urandom_range(8, 15)), 16'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_energy();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 400));
      default: return 16'($urandom);
    endcase
  endfunction

  // one frame with a random number of elements, mostly short
  task automatic send_random_frame();
    int len;
    len = $urandom_range(0, 9) == 0 ? $urandom_range(30, 35) : $urandom_range(1, 6);
    for (int i = 0; i < len; i++)
      send_element($urandom_range(0, 3) != 0, $urandom_range(0, 2) == 0,
                   pick_energy(), i == len - 1);
  endtask

  task automatic run_random(int n_items);
    int goal;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      if ($urandom_range(0, 14) == 0) send_release_all();
      else send_random_frame();
    end
  endtask

  task automatic test_directed();
    // first frame fills every entry so none is read unwritten
    for (int p = 0; p < PITCHES; p++)
      send_element(p < 12, p < 6, p == 0 ? 16'hFFFF : p == 1 ? 16'd131 : 16'd0,
                   p == PITCHES - 1);
    send_element(1'b1, 1'b1, 16'h0000, 1'b1);
    send_element(1'b1, 1'b0, 16'h0000, 1'b1);
    send_element(1'b1, 1'b1, 16'hFFFF, 1'b1);
    send_element(1'b0, 1'b0, 16'h0000, 1'b0);
    send_element(1'b1, 1'b1, 16'h8000, 1'b1);
    send_release_all();
    send_release_all();
    send_element(1'b0, 1'b0, 16'h0000, 1'b1);
  endtask

  task automatic test_defaults();
    run_random(15);
  endtask

  task automatic test_low_extremes();
    write_all(16'h0, 16'h0, 16'h0, 16'h1, 16'h1, 16'h0, 16'h0, 16'h0);
    run_random(12);
    write_all(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h1, 16'h7F);
    run_random(8);
  endtask

  task automatic test_high_extremes();
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hF, 16'hF, 16'hF, 16'hFE, 16'h7F);
    run_random(12);
    write_all(16'h100, 16'h200, 16'h800, 16'h3, 16'h2, 16'hF, 16'hFF, 16'h70);
    run_random(8);
  endtask

  task automatic test_random_settings();
    write_all(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
              16'($urandom_range(0, 4000)), 16'($urandom_range(1, 4)),
              16'($urandom_range(1, 6)), 16'($urandom_range(0, 8)),
              16'($urandom_range(2, 30)), 16'hFFFF);
    run_random(10);
    quiet = 1'b1;
    run_random(8);
  endtask

  initial begin
    build_thresholds();
    reset_tracker();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_defaults();
    test_low_extremes();
    test_high_extremes();
    test_random_settings();
    idle(1);
    while (events_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d beats (%0d release-all), checked %0d events, %0d note-ons",
             items_sent, release_alls, events_seen, note_ons);
    $display("settings covered: reset values, low and high extremes, random");
    if (errors == 0 && events_due.size() == 0) begin
      $display("tb_pitch_note_event_tracker_unit: PASS");
    end else begin
      $display("%0d mismatches, %0d events missing", errors, events_due.size());
      $display("tb_pitch_note_event_tracker_unit: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
src/pnet_pkg.sv
src/pitch_note_event_tracker_unit.sv
tb/tb_pitch_note_event_tracker_unit.sv
